// ===== src/idle_timeout_table_top_defines.svh =====
// Assertion macros shared by the RTL.
`ifndef IDLE_TIMEOUT_TABLE_TOP_DEFINES_SVH
`define IDLE_TIMEOUT_TABLE_TOP_DEFINES_SVH
`ifndef SYNTH
`define ITT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ITT_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ITT_ASSERT(lbl, clk, rst_n, prop, msg)
`define ITT_ASSERT_RST(lbl, clk, prop, msg)
`endif
`endif

// ===== src/itt_pkg.sv =====
package itt_pkg;
  localparam int DefCapacity = 32;
  localparam int MaxResults = 32;
  localparam logic [30:0] LimitReset = 31'd1000;

  typedef enum logic [1:0] {
    MODE_TOUCH  = 2'd0,
    MODE_UPDATE = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_QUERY  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;
endpackage

// ===== src/idle_timeout_table_top.sv =====
// Idle timeout table. Keeps up to CAPACITY keys with their last-touch times
// in a doubly linked recency list held in memories. A command word is taken
// at a clock edge where start is high and busy is low; every result word is
// shown for exactly one cycle with out_valid high and cannot be stalled, so
// the receiver must take it. Touch, update and remove scan the key memory
// slot by slot (read, then compare) to find the key and, for an insert, the
// first free slot. A decision step and the list edits (unlink, then push at
// the newest end) follow. The single result word appears in the first cycle
// with busy low. A query walks the list from the oldest entry, reading and
// then checking each entry; the walk ends when it runs off the list, hits
// the result cap or meets a fresh entry. Each expired key's word is held in
// a register until the next step shows whether more follow, so that the
// final one can carry the last flag, and the final word appears in the
// first cycle with busy low. The serial scan through the key memory's single
// read port sets the busy time. There is no clearing pass after reset; the
// used bits are flip-flops cleared at once. The timeout limit is written
// only while the block is idle and no command is offered.
`include "idle_timeout_table_top_defines.svh"

module idle_timeout_table_top #(
  parameter int CAPACITY = itt_pkg::DefCapacity
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_mode,
  input  logic signed [31:0] in_key,
  input  logic [47:0]        in_now_ms,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [30:0]        cfg_timeout_limit,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_expired_key,
  output logic               out_key_valid,
  output logic               out_last_result
);
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int RW = $clog2(itt_pkg::MaxResults + 1);

  // One-hot sequencer states.
  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_SCAN  = 10'b0000000010,
    S_SCANW = 10'b0000000100,
    S_DECIDE= 10'b0000001000,
    S_ULNK1 = 10'b0000010000,
    S_ULNK2 = 10'b0000100000,
    S_PUSH1 = 10'b0001000000,
    S_PUSH2 = 10'b0010000000,
    S_QRD   = 10'b0100000000,
    S_QCHK  = 10'b1000000000
  } state_t;

  // Memories: key, time and both links; one read and one write port each, registered read.
  logic [31:0]   key_mem   [CAPACITY];
  logic [47:0]   time_mem  [CAPACITY];
  logic [AW-1:0] older_mem [CAPACITY];
  logic [AW-1:0] newer_mem [CAPACITY];
  logic [CAPACITY-1:0] used_r, used_nxt;

  state_t state_r, state_nxt;
  logic [1:0]    mode_r, mode_nxt;
  logic [31:0]   key_r, key_nxt;
  logic [47:0]   now_r, now_nxt;
  logic [30:0]   limit_r, limit_nxt;
  logic [AW-1:0] newest_r, newest_nxt, oldest_r, oldest_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;      // scan or walk counter
  logic [AW-1:0] addr_r, addr_nxt;    // slot being read
  logic [AW-1:0] hit_r, hit_nxt;
  logic          found_r, found_nxt;
  logic [AW-1:0] free_r, free_nxt;
  logic          has_free_r, has_free_nxt;
  logic [RW-1:0] nres_r, nres_nxt;
  logic          insert_r, insert_nxt;
  logic          remove_r, remove_nxt;

  logic [31:0]   rd_key_r;
  logic [47:0]   rd_time_r;
  logic [AW-1:0] rd_older_r, rd_newer_r;
  logic          rd_en;
  logic [AW-1:0] rd_addr;

  // Write ports, one per memory.
  logic          kw_en, tw_en, ow_en, nw_en;
  logic [AW-1:0] kw_addr, tw_addr, ow_addr, nw_addr;
  logic [AW-1:0] ow_data, nw_data;

  logic          ov_r, ov_nxt, ok_v_r, ok_v_nxt, olast_r, olast_nxt;
  logic [1:0]    ost_r, ost_nxt;
  logic [31:0]   okey_r, okey_nxt;

  logic [48:0]   elapsed;
  logic          expired;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_key_r   <= key_mem[rd_addr];
      rd_time_r  <= time_mem[rd_addr];
      rd_older_r <= older_mem[rd_addr];
      rd_newer_r <= newer_mem[rd_addr];
    end
    if (kw_en) key_mem[kw_addr] <= key_r;
    if (tw_en) time_mem[tw_addr] <= now_r;
    if (ow_en) older_mem[ow_addr] <= ow_data;
    if (nw_en) newer_mem[nw_addr] <= nw_data;
  end

  // Elapsed time with the borrow kept: a borrow means time went backwards.
  assign elapsed = {1'b0, now_r} - {1'b0, rd_time_r};
  assign expired = !elapsed[48] && (elapsed[47:0] > {17'd0, limit_r});

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE) && !start;

  always_comb begin
    state_nxt = state_r;
    mode_nxt = mode_r; key_nxt = key_r; now_nxt = now_r;
    limit_nxt = limit_r;
    newest_nxt = newest_r; oldest_nxt = oldest_r; count_nxt = count_r;
    idx_nxt = idx_r; addr_nxt = addr_r;
    hit_nxt = hit_r; found_nxt = found_r; free_nxt = free_r;
    has_free_nxt = has_free_r; nres_nxt = nres_r;
    insert_nxt = insert_r; remove_nxt = remove_r;
    used_nxt = used_r;
    rd_en = 1'b0; rd_addr = addr_r;
    kw_en = 1'b0; kw_addr = hit_r;
    tw_en = 1'b0; tw_addr = hit_r;
    ow_en = 1'b0; ow_addr = hit_r; ow_data = hit_r;
    nw_en = 1'b0; nw_addr = hit_r; nw_data = hit_r;
    ov_nxt = 1'b0; ost_nxt = itt_pkg::ST_OK; okey_nxt = '0;
    ok_v_nxt = 1'b0; olast_nxt = 1'b0;

    if (cfg_valid && cfg_ready) limit_nxt = cfg_timeout_limit;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          mode_nxt = in_mode; key_nxt = in_key; now_nxt = in_now_ms;
          idx_nxt = '0; found_nxt = 1'b0; has_free_nxt = 1'b0;
          nres_nxt = '0; insert_nxt = 1'b0; remove_nxt = 1'b0;
          if (in_mode == itt_pkg::MODE_QUERY) begin
            addr_nxt = oldest_r;
            state_nxt = S_QRD;
          end else begin
            addr_nxt = '0;
            state_nxt = S_SCAN;
          end
        end
      end
      // Scan: issue a read of slot idx, compare it next cycle.
      S_SCAN: begin
        rd_en = 1'b1; rd_addr = idx_r[AW-1:0];
        addr_nxt = idx_r[AW-1:0];
        state_nxt = S_SCANW;
      end
      S_SCANW: begin
        if (used_r[addr_r] && rd_key_r == key_r && !found_r) begin
          found_nxt = 1'b1; hit_nxt = addr_r;
        end
        if (!used_r[addr_r] && !has_free_r) begin
          has_free_nxt = 1'b1; free_nxt = addr_r;
        end
        if (idx_r == CW'(CAPACITY - 1)) begin
          state_nxt = S_DECIDE;
        end else begin
          idx_nxt = idx_r + 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_DECIDE: begin
        state_nxt = S_IDLE;
        ov_nxt = 1'b1; olast_nxt = 1'b1;
        if (found_r) begin
          remove_nxt = (mode_r == itt_pkg::MODE_REMOVE);
          // Read the hit slot's links for the unlink.
          rd_en = 1'b1; rd_addr = hit_r;
          ov_nxt = 1'b0; olast_nxt = 1'b0;
          state_nxt = S_ULNK1;
        end else if (mode_r != itt_pkg::MODE_TOUCH) begin
          ost_nxt = itt_pkg::ST_NOT_FOUND;
        end else if (!has_free_r) begin
          ost_nxt = itt_pkg::ST_FULL;
        end else begin
          hit_nxt = free_r; insert_nxt = 1'b1;
          used_nxt[free_r] = 1'b1;
          ov_nxt = 1'b0; olast_nxt = 1'b0;
          state_nxt = S_PUSH1;
        end
      end
      // Unlink: rd_older_r and rd_newer_r hold the hit slot's links.
      S_ULNK1: begin
        if (count_r <= CW'(1)) begin
          count_nxt = '0; newest_nxt = '0; oldest_nxt = '0;
          state_nxt = S_PUSH1;
        end else begin
          if (hit_r == newest_r) newest_nxt = rd_older_r;
          else begin
            ow_en = 1'b1; ow_addr = rd_newer_r; ow_data = rd_older_r;
          end
          if (hit_r == oldest_r) oldest_nxt = rd_newer_r;
          else begin
            nw_en = 1'b1; nw_addr = rd_older_r; nw_data = rd_newer_r;
          end
          count_nxt = count_r - 1'b1;
          state_nxt = S_PUSH1;
        end
        if (remove_r) begin
          used_nxt[hit_r] = 1'b0;
          ov_nxt = 1'b1; olast_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      // Push at the newest end; the time, and for an insert the key, are written here too.
      S_PUSH1: begin
        tw_en = 1'b1;
        kw_en = insert_r;
        ow_en = 1'b1; ow_data = (count_r == '0) ? hit_r : newest_r;
        nw_en = 1'b1; nw_data = hit_r;
        if (count_r == '0) begin
          oldest_nxt = hit_r;
          newest_nxt = hit_r;
          count_nxt = CW'(1);
          ov_nxt = 1'b1; olast_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_PUSH2;
        end
      end
      S_PUSH2: begin
        nw_en = 1'b1; nw_addr = newest_r; nw_data = hit_r;
        newest_nxt = hit_r;
        count_nxt = count_r + 1'b1;
        ov_nxt = 1'b1; olast_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      // Query walk from the oldest entry.
      S_QRD: begin
        if (idx_r >= count_r || nres_r == RW'(itt_pkg::MaxResults)) begin
          ov_nxt = (nres_r == '0); olast_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          rd_en = 1'b1; rd_addr = addr_r;
          state_nxt = S_QCHK;
        end
      end
      S_QCHK: begin
        if (expired) begin
          ov_nxt = 1'b1; ok_v_nxt = 1'b1; okey_nxt = rd_key_r;
          nres_nxt = nres_r + 1'b1;
          idx_nxt = idx_r + 1'b1;
          addr_nxt = rd_newer_r;
          state_nxt = S_QRD;
        end else begin
          ov_nxt = (nres_r == '0); olast_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Query results are held in a register so the final one can carry the last
  // flag: a word leaves only once the next step shows whether more follow.
  logic          hv_r;
  logic [31:0]   hkey_r;
  logic          fin;
  assign fin = olast_nxt && (state_r == S_QRD || state_r == S_QCHK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      limit_r <= itt_pkg::LimitReset;
      newest_r <= '0; oldest_r <= '0; count_r <= '0;
      used_r <= '0;
      ov_r <= 1'b0; hv_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      limit_r <= limit_nxt;
      newest_r <= newest_nxt; oldest_r <= oldest_nxt; count_r <= count_nxt;
      used_r <= used_nxt;
      if (ok_v_nxt) begin
        // Emit the held word (not last) and hold the new one.
        ov_r <= hv_r;
        ost_r <= itt_pkg::ST_OK; okey_r <= hkey_r; ok_v_r <= 1'b1;
        olast_r <= 1'b0;
        hv_r <= 1'b1; hkey_r <= okey_nxt;
      end else if (fin && hv_r) begin
        ov_r <= 1'b1; ost_r <= itt_pkg::ST_OK; okey_r <= hkey_r;
        ok_v_r <= 1'b1; olast_r <= 1'b1;
        hv_r <= 1'b0;
      end else begin
        ov_r <= ov_nxt; ost_r <= ost_nxt; okey_r <= okey_nxt;
        ok_v_r <= 1'b0; olast_r <= olast_nxt;
      end
    end
    mode_r <= mode_nxt; key_r <= key_nxt; now_r <= now_nxt;
    idx_r <= idx_nxt; addr_r <= addr_nxt; hit_r <= hit_nxt;
    found_r <= found_nxt; free_r <= free_nxt; has_free_r <= has_free_nxt;
    nres_r <= nres_nxt; insert_r <= insert_nxt; remove_r <= remove_nxt;
  end

  assign out_valid       = ov_r;
  assign out_status      = ost_r;
  assign out_expired_key = okey_r;
  assign out_key_valid   = ok_v_r;
  assign out_last_result = olast_r;

  // While idle, the entry count matches the number of used slots.
  logic count_ok;
  assign count_ok = (state_r != S_IDLE) || ($countones(used_r) == 32'(count_r));

  `ITT_ASSERT(a_count_bound, clk, rst_n, count_r <= CW'(CAPACITY), "count over capacity")
  `ITT_ASSERT(a_count_used, clk, rst_n, count_ok, "count disagrees with used bits")
  `ITT_ASSERT(a_no_start_busy, clk, rst_n, (state_r != S_IDLE) |-> busy, "busy low while working")
  `ITT_ASSERT(a_key_valid_ok, clk, rst_n, out_valid && out_key_valid |-> out_status == itt_pkg::ST_OK, "bad status")
  `ITT_ASSERT_RST(a_rst_idle, clk, !rst_n |=> !out_valid, "result after reset")
endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  localparam int Cap = 32;
  localparam int TimeoutCycles = 2000000;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [1:0]         in_mode;
  logic signed [31:0] in_key;
  logic [47:0]        in_now_ms;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [30:0]        cfg_timeout_limit;
  logic               out_valid;
  logic [1:0]         out_status;
  logic signed [31:0] out_expired_key;
  logic               out_key_valid;
  logic               out_last_result;

  idle_timeout_table_top #(.CAPACITY(Cap)) u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_mode(in_mode), .in_key(in_key), .in_now_ms(in_now_ms),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_timeout_limit(cfg_timeout_limit),
    .out_valid(out_valid), .out_status(out_status),
    .out_expired_key(out_expired_key), .out_key_valid(out_key_valid),
    .out_last_result(out_last_result)
  );

  // One expected result word.
  typedef struct packed {
    itt_pkg::status_t status;
    logic [31:0]      exp_key;
    logic             key_valid;
    logic             last;
  } result_word_t;

  result_word_t pending_words[$];
  int           error_count;
  int           sender_idle_pct;

  // Shadow copy of the table. The recency order is a plain queue of slot
  // indexes, oldest at the front; that is all the hardware's links encode.
  logic [31:0]  shadow_key[Cap];
  logic [47:0]  shadow_time[Cap];
  logic         shadow_used[Cap];
  int           recency_order[$];
  logic [30:0]  shadow_limit;

  // A small pool of keys keeps hits and misses both likely.
  logic [31:0]  key_pool[16];
  logic [47:0]  clock_ms;

  initial begin
    clk = 1'b0;
  end
  always #1 clk = ~clk;

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    error_count++;
  endtask

  function automatic int find_slot(input logic [31:0] k);
    for (int i = 0; i < Cap; i++) begin
      if (shadow_used[i] && shadow_key[i] == k) return i;
    end
    return -1;
  endfunction

  function automatic void drop_from_order(input int s);
    for (int i = 0; i < recency_order.size(); i++) begin
      if (recency_order[i] == s) begin
        recency_order.delete(i);
        return;
      end
    end
  endfunction

  // Appends one expected word behind those already waiting.
  function automatic void queue_expected(input result_word_t w);
    pending_words.insert(pending_words.size(), w);
  endfunction

  // Puts a slot at the newest end of the recency order.
  function automatic void make_newest(input int s);
    recency_order.insert(recency_order.size(), s);
  endfunction

  // Works out the result words of one command and updates the shadow table.
  function automatic void predict_table_op(input itt_pkg::mode_t m, input logic [31:0] k,
                                           input logic [47:0] now);
    result_word_t w;
    int s;
    int n;
    int cur;
    w = '{status: itt_pkg::ST_OK, exp_key: 32'd0, key_valid: 1'b0, last: 1'b1};
    if (m == itt_pkg::MODE_QUERY) begin
      n = 0;
      foreach (recency_order[i]) begin
        cur = recency_order[i];
        if (n >= itt_pkg::MaxResults) break;
        // A last touch in the future never counts as expired.
        if (now < shadow_time[cur] || now - shadow_time[cur] <= {17'd0, shadow_limit}) break;
        queue_expected('{status: itt_pkg::ST_OK, exp_key: shadow_key[cur],
                         key_valid: 1'b1, last: 1'b0});
        n++;
      end
      if (n == 0) queue_expected(w);
      else pending_words[pending_words.size() - 1].last = 1'b1;
      return;
    end
    s = find_slot(k);
    if (m == itt_pkg::MODE_REMOVE) begin
      if (s < 0) w.status = itt_pkg::ST_NOT_FOUND;
      else begin
        drop_from_order(s);
        shadow_used[s] = 1'b0;
      end
    end else if (s >= 0) begin
      shadow_time[s] = now;
      drop_from_order(s);
      make_newest(s);
    end else if (m == itt_pkg::MODE_UPDATE) begin
      w.status = itt_pkg::ST_NOT_FOUND;
    end else begin
      s = -1;
      for (int i = 0; i < Cap; i++) begin
        if (!shadow_used[i]) begin
          s = i;
          break;
        end
      end
      if (s < 0) w.status = itt_pkg::ST_FULL;
      else begin
        shadow_used[s] = 1'b1;
        shadow_key[s]  = k;
        shadow_time[s] = now;
        make_newest(s);
      end
    end
    queue_expected(w);
  endfunction

  // Sends one command word, after a random gap when the sender idles. Start
  // stays high after acceptance until the next word or an idle cycle.
  task automatic send_word(input itt_pkg::mode_t m, input logic [31:0] k,
                           input logic [47:0] now);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start     <= 1'b1;
    in_mode   <= m;
    in_key    <= k;
    in_now_ms <= now;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_table_op(m, k, now);
  endtask

  // Waits until every expected word is in, then idles so the block is quiet.
  task automatic drain();
    start <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (Cap + 20) @(posedge clk);
  endtask

  task automatic write_limit(input logic [30:0] value);
    cfg_valid         <= 1'b1;
    cfg_timeout_limit <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    shadow_limit = value;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Checks every result word against the oldest expectation.
  always @(posedge clk) begin
    result_word_t w;
    if (rst_n && out_valid) begin
      if (pending_words.size() == 0) begin
        report_mismatch("result word with none expected");
      end else begin
        w = pending_words.pop_front();
        if (out_status != w.status)
          report_mismatch($sformatf("status %0d, expected %0d", out_status, w.status));
        if (out_expired_key != w.exp_key)
          report_mismatch($sformatf("key %0h, expected %0h", out_expired_key, w.exp_key));
        if (out_key_valid != w.key_valid)
          report_mismatch($sformatf("key_valid %0b, expected %0b", out_key_valid, w.key_valid));
        if (out_last_result != w.last)
          report_mismatch($sformatf("last %0b, expected %0b", out_last_result, w.last));
      end
    end
  end

  // Extreme keys and times, every mode, misses, a query with nothing expired,
  // and time that runs backwards.
  task automatic test_directed();
    send_word(itt_pkg::MODE_QUERY, 32'h0, 48'h0);
    send_word(itt_pkg::MODE_UPDATE, 32'h8000_0000, 48'h0);
    send_word(itt_pkg::MODE_REMOVE, 32'h7FFF_FFFF, 48'h0);
    send_word(itt_pkg::MODE_TOUCH, 32'h8000_0000, 48'h0);
    send_word(itt_pkg::MODE_TOUCH, 32'h7FFF_FFFF, 48'd500);
    send_word(itt_pkg::MODE_TOUCH, 32'hFFFF_FFFF, 48'd2000);
    send_word(itt_pkg::MODE_UPDATE, 32'h8000_0000, 48'd1500);
    send_word(itt_pkg::MODE_QUERY, 32'h0, 48'd2000);
    send_word(itt_pkg::MODE_QUERY, 32'h0, 48'd3600);
    send_word(itt_pkg::MODE_QUERY, 32'h0, 48'd100);
    send_word(itt_pkg::MODE_QUERY, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    send_word(itt_pkg::MODE_REMOVE, 32'h7FFF_FFFF, 48'd0);
    send_word(itt_pkg::MODE_REMOVE, 32'h7FFF_FFFF, 48'd0);
    send_word(itt_pkg::MODE_TOUCH, 32'h0, 48'hFFFF_FFFF_FFFF);
    send_word(itt_pkg::MODE_QUERY, 32'h0, 48'd10);
    drain();
  endtask

  // Fills the table past capacity, then lets a query report every entry.
  task automatic test_full_table();
    for (int i = 0; i < Cap + 2; i++)
      send_word(itt_pkg::MODE_TOUCH, 32'h1000 + i, 48'd5000 + i);
    send_word(itt_pkg::MODE_UPDATE, 32'h1000 + Cap + 1, 48'd6000);
    send_word(itt_pkg::MODE_QUERY, 32'h0, 48'h8000_0000_0000);
    for (int i = 0; i < Cap; i++)
      send_word(itt_pkg::MODE_REMOVE, 32'h1000 + i, 48'd0);
    drain();
  endtask

  task automatic test_random(input int count, input int idle_pct);
    itt_pkg::mode_t m;
    sender_idle_pct = idle_pct;
    for (int i = 0; i < count; i++) begin
      m = itt_pkg::mode_t'($urandom_range(3));
      clock_ms += $urandom_range(600);
      // Now and then time runs backwards.
      if ($urandom_range(9) == 0) clock_ms -= $urandom_range(800);
      if ($urandom_range(19) == 0)
        send_word(m, $urandom(), 48'({$urandom(), $urandom()}));
      else
        send_word(m, key_pool[$urandom_range(15)], clock_ms);
    end
    drain();
  endtask

  initial begin
    rst_n             = 1'b0;
    start             = 1'b0;
    in_mode           = itt_pkg::MODE_TOUCH;
    in_key            = '0;
    in_now_ms         = '0;
    cfg_valid         = 1'b0;
    cfg_timeout_limit = '0;
    error_count       = 0;
    sender_idle_pct   = 0;
    shadow_limit      = itt_pkg::LimitReset;
    clock_ms          = 48'd100000;
    for (int i = 0; i < Cap; i++) shadow_used[i] = 1'b0;
    foreach (key_pool[i]) key_pool[i] = $urandom();
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    write_limit(31'd0);
    test_full_table();
    write_limit(31'h7FFF_FFFF);
    test_random(15, 0);
    write_limit(31'd700);
    test_random(30, 53);
    write_limit(31'd300);
    test_random(25, 0);
    write_limit(31'd1500);
    test_random(17, 33);

    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Guards against a hung handshake.
  initial begin
    #(TimeoutCycles * 2);
    $display("TB_ERROR");
    $finish;
  end
endmodule
